@@ rtl/sca_pkg.sv @@
// Shared types and constants for the stack calculator ALU.
`default_nettype none

package sca_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int QUEUE_DEPTH     = 2;
   localparam int WORD_W          = 32;
   localparam int DIV_STEPS       = 32;
   localparam int SQRT_STEPS      = 16;
   localparam int STEP_W          = 5;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_SQRT = 3'd5,
      OP_OUT  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_NEGSQRT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_PUSH,
      KIND_ARITH,
      KIND_SQRT,
      KIND_OUT,
      KIND_NOP
   } kind_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic {
      UM_DIV,
      UM_SQRT
   } unit_mode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_ITER,
      BK_SEND
   } back_state_type;

   typedef enum logic [2:0] {
      TOP_OPERAND,
      TOP_RDDATA,
      TOP_ADD,
      TOP_SUB,
      TOP_MUL,
      TOP_UNIT
   } top_src_type;

   typedef struct packed {
      kind_type          kind;
      alu_op_type        alu_op;
      logic [WORD_W-1:0] operand;
   } cmd_type;

   typedef struct packed {
      logic              start;
      unit_mode_type     mode;
      logic [WORD_W-1:0] opa;
      logic [WORD_W-1:0] opb;
   } unit_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } unit_rsp_type;

endpackage

`default_nettype wire

@@ rtl/sca_front.sv @@
// Front end: takes commands and decodes them into queue entries.
`default_nettype none

module sca_front (
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [31:0]     req_tdata,   // [31:0] operand
   input  wire logic [2:0]      req_tuser,   // [2:0] operation
   output logic                 q_push,
   output sca_pkg::cmd_type     q_data,
   input  wire logic            q_full
);
   import sca_pkg::*;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_data.operand = req_tdata;
      q_data.alu_op  = ALU_ADD;
      case (req_tuser)
         OP_PUSH: q_data.kind = KIND_PUSH;
         OP_ADD: begin
            q_data.kind   = KIND_ARITH;
            q_data.alu_op = ALU_ADD;
         end
         OP_SUB: begin
            q_data.kind   = KIND_ARITH;
            q_data.alu_op = ALU_SUB;
         end
         OP_MUL: begin
            q_data.kind   = KIND_ARITH;
            q_data.alu_op = ALU_MUL;
         end
         OP_DIV: begin
            q_data.kind   = KIND_ARITH;
            q_data.alu_op = ALU_DIV;
         end
         OP_SQRT: q_data.kind = KIND_SQRT;
         OP_OUT:  q_data.kind = KIND_OUT;
         default: q_data.kind = KIND_NOP;
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/sca_queue.sv @@
// Short command queue between front end and execution back end.
`default_nettype none

module sca_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sca_pkg::cmd_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output sca_pkg::cmd_type       pop_data,
   output logic                   empty
);
   import sca_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sca_iter.sv @@
// Iterative unit: signed truncating divide and floor square root, one step per cycle.
`default_nettype none

module sca_iter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sca_pkg::unit_req_type  unit_req,
   output sca_pkg::unit_rsp_type       unit_rsp
);
   import sca_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   unit_mode_type       mode_ff, mode_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                neg_ff, neg_in;
   logic [WORD_W:0]     acc_ff, acc_in;
   logic [WORD_W-1:0]   quo_ff, quo_in;
   logic [WORD_W-1:0]   den_ff, den_in;

   logic [WORD_W-1:0]   mag_a, mag_b;
   logic [WORD_W:0]     shifted, diff, trial;
   logic                last_step;

   assign mag_a = unit_req.opa[WORD_W-1] ? WORD_W'(0) - unit_req.opa : unit_req.opa;
   assign mag_b = unit_req.opb[WORD_W-1] ? WORD_W'(0) - unit_req.opb : unit_req.opb;

   assign shifted = {acc_ff[WORD_W-1:0], quo_ff[WORD_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign trial   = {1'b0, quo_ff} + {1'b0, den_ff};

   assign last_step = (mode_ff == UM_DIV) ? (step_ff == STEP_W'(DIV_STEPS - 1))
                                          : (step_ff == STEP_W'(SQRT_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (unit_req.start) begin
         busy_in = 1'b1;
         mode_in = unit_req.mode;
         step_in = '0;
         if (unit_req.mode == UM_DIV) begin
            neg_in = unit_req.opa[WORD_W-1] ^ unit_req.opb[WORD_W-1];
            acc_in = '0;
            quo_in = mag_a;
            den_in = mag_b;
         end else begin
            neg_in = 1'b0;
            acc_in = {1'b0, unit_req.opa};
            quo_in = '0;
            den_in = WORD_W'(1) << (WORD_W - 2);
         end
      end else if (busy_ff) begin
         step_in = step_ff + STEP_W'(1);
         if (mode_ff == UM_DIV) begin
            if (!diff[WORD_W]) begin
               acc_in = diff;
               quo_in = {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               acc_in = shifted;
               quo_in = {quo_ff[WORD_W-2:0], 1'b0};
            end
         end else begin
            if (acc_ff >= trial) begin
               acc_in = acc_ff - trial;
               quo_in = (quo_ff >> 1) + den_ff;
            end else begin
               quo_in = quo_ff >> 1;
            end
            den_in = den_ff >> 2;
         end
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         mode_ff <= UM_DIV;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         mode_ff <= mode_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign unit_rsp.done   = done_ff;
   assign unit_rsp.result = (mode_ff == UM_DIV && neg_ff) ? WORD_W'(0) - quo_ff : quo_ff;

endmodule

`default_nettype wire

@@ rtl/sca_back.sv @@
// Back end: operand stack, command sequencer, adder/multiplier and result register.
`default_nettype none

module sca_back #(
   parameter int STACK_DEPTH = sca_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire sca_pkg::cmd_type       q_data,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output sca_pkg::unit_req_type       unit_req,
   input  wire sca_pkg::unit_rsp_type  unit_rsp,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic [3:0]                  rsp_tuser
);
   import sca_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WORD_W-1:0]  top_ff, top_in;
   logic [WORD_W-1:0]  stack_mem [STACK_DEPTH];
   logic [WORD_W-1:0]  rd_data_ff;
   logic [WORD_W-1:0]  mul_ff;
   status_type         status_ff;
   logic [WORD_W-1:0]  shown_ff;
   logic               shown_valid_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [WORD_W-1:0]  rsp_value_ff;
   logic               rsp_shown_ff;

   logic [CNT_W-1:0]   wr_idx, rd_idx;
   logic               is_full, is_empty, lt_two;
   logic               out_free;

   logic               mem_we, mem_re, top_we, cnt_inc, cnt_dec, mul_we;
   top_src_type        top_sel;
   logic               res_we, res_shown, rsp_load;
   status_type         res_status;

   assign wr_idx   = count_ff - CNT_W'(1);
   assign rd_idx   = count_ff - CNT_W'(2);
   assign is_full  = (count_ff >= CNT_W'(STACK_DEPTH));
   assign is_empty = (count_ff == '0);
   assign lt_two   = (count_ff < CNT_W'(2));
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               case (q_data.kind)
                  KIND_ARITH: state_in = lt_two ? BK_SEND : BK_READ;
                  KIND_SQRT:  state_in = (is_empty || top_ff[WORD_W-1]) ? BK_SEND : BK_ITER;
                  KIND_OUT:   state_in = (!is_empty && !lt_two) ? BK_READ : BK_SEND;
                  default:    state_in = BK_SEND;
               endcase
            end
         end
         BK_READ: begin
            if (cmd_ff.kind == KIND_ARITH && cmd_ff.alu_op == ALU_MUL) begin
               state_in = BK_MUL;
            end else if (cmd_ff.kind == KIND_ARITH && cmd_ff.alu_op == ALU_DIV
                         && top_ff != '0) begin
               state_in = BK_ITER;
            end else begin
               state_in = BK_SEND;
            end
         end
         BK_MUL:  state_in = BK_SEND;
         BK_ITER: state_in = unit_rsp.done ? BK_SEND : BK_ITER;
         BK_SEND: state_in = out_free ? BK_IDLE : BK_SEND;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      top_we        = 1'b0;
      top_sel       = TOP_OPERAND;
      cnt_inc       = 1'b0;
      cnt_dec       = 1'b0;
      mul_we        = 1'b0;
      res_we        = 1'b0;
      res_status    = ST_OK;
      res_shown     = 1'b0;
      rsp_load      = 1'b0;
      unit_req.start = 1'b0;
      unit_req.mode  = UM_DIV;
      unit_req.opa   = rd_data_ff;
      unit_req.opb   = top_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_data.kind)
                  KIND_PUSH: begin
                     res_we = 1'b1;
                     if (is_full) begin
                        res_status = ST_OVER;
                     end else begin
                        mem_we  = !is_empty;
                        top_we  = 1'b1;
                        top_sel = TOP_OPERAND;
                        cnt_inc = 1'b1;
                     end
                  end
                  KIND_ARITH: begin
                     if (lt_two) begin
                        res_we     = 1'b1;
                        res_status = ST_UNDER;
                     end else begin
                        mem_re = 1'b1;
                     end
                  end
                  KIND_SQRT: begin
                     if (is_empty) begin
                        res_we     = 1'b1;
                        res_status = ST_UNDER;
                     end else if (top_ff[WORD_W-1]) begin
                        res_we     = 1'b1;
                        res_status = ST_NEGSQRT;
                     end else begin
                        unit_req.start = 1'b1;
                        unit_req.mode  = UM_SQRT;
                        unit_req.opa   = top_ff;
                     end
                  end
                  KIND_OUT: begin
                     res_we = 1'b1;
                     if (is_empty) begin
                        res_status = ST_UNDER;
                     end else begin
                        res_shown = 1'b1;
                        if (lt_two) begin
                           cnt_dec = 1'b1;
                        end else begin
                           mem_re = 1'b1;
                        end
                     end
                  end
                  default: res_we = 1'b1;
               endcase
            end
         end
         BK_READ: begin
            if (cmd_ff.kind == KIND_OUT) begin
               top_we  = 1'b1;
               top_sel = TOP_RDDATA;
               cnt_dec = 1'b1;
            end else begin
               case (cmd_ff.alu_op)
                  ALU_ADD: begin
                     top_we  = 1'b1;
                     top_sel = TOP_ADD;
                     cnt_dec = 1'b1;
                     res_we  = 1'b1;
                  end
                  ALU_SUB: begin
                     top_we  = 1'b1;
                     top_sel = TOP_SUB;
                     cnt_dec = 1'b1;
                     res_we  = 1'b1;
                  end
                  ALU_MUL: mul_we = 1'b1;
                  default: begin
                     if (top_ff == '0) begin
                        res_we     = 1'b1;
                        res_status = ST_DIVZERO;
                     end else begin
                        unit_req.start = 1'b1;
                        unit_req.mode  = UM_DIV;
                     end
                  end
               endcase
            end
         end
         BK_MUL: begin
            top_we  = 1'b1;
            top_sel = TOP_MUL;
            cnt_dec = 1'b1;
            res_we  = 1'b1;
         end
         BK_ITER: begin
            if (unit_rsp.done) begin
               top_we  = 1'b1;
               top_sel = TOP_UNIT;
               cnt_dec = (cmd_ff.alu_op == ALU_DIV) && (cmd_ff.kind == KIND_ARITH);
               res_we  = 1'b1;
            end
         end
         BK_SEND: rsp_load = out_free;
         default: ;
      endcase
   end

   always_comb begin
      case (top_sel)
         TOP_OPERAND: top_in = cmd_ff.operand;
         TOP_RDDATA:  top_in = rd_data_ff;
         TOP_ADD:     top_in = rd_data_ff + top_ff;
         TOP_SUB:     top_in = rd_data_ff - top_ff;
         TOP_MUL:     top_in = mul_ff;
         TOP_UNIT:    top_in = unit_rsp.result;
         default:     top_in = top_ff;
      endcase
      if (state_ff == BK_IDLE) begin
         top_in = q_data.operand;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      if (top_we) begin
         top_ff <= top_in;
      end
      if (mul_we) begin
         mul_ff <= WORD_W'(rd_data_ff * top_ff);
      end
      if (res_we) begin
         status_ff      <= res_status;
         shown_ff       <= res_shown ? top_ff : '0;
         shown_valid_ff <= res_shown;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= shown_ff;
         rsp_shown_ff  <= shown_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx[ADDR_W-1:0]] <= top_ff;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_idx[ADDR_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_shown_ff, rsp_status_ff};

endmodule

`default_nettype wire

@@ rtl/stack_calculator_alu_unit.sv @@
// Top level of the RPN stack calculator ALU.
//
//   channel  direction  tdata               tuser
//   req      in         [31:0] operand      [2:0] operation
//   rsp      out        [31:0] shown_value  [2:0] status, [3] shown_valid
//
// One result per command. Push, no-op, single-element out and most errors go
// straight to the result register; add/sub/out and divide by zero first read
// the second stack entry, mul also registers the product, and sqrt and div
// wait on the one-bit-per-cycle divide/square-root unit. A two-entry queue
// takes commands until full while the back end works or the result waits.
// Synchronous reset empties stack and queue; stack contents are not cleared.
`default_nettype none

module stack_calculator_alu_unit #(
   parameter int STACK_DEPTH = sca_pkg::STACK_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [31:0]  req_tdata,   // [31:0] operand
   input  wire logic [2:0]   req_tuser,   // [2:0] operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [31:0] shown_value
   output logic [3:0]        rsp_tuser    // [2:0] status, [3] shown_valid
);
   import sca_pkg::*;

   logic          q_push, q_full, q_pop, q_empty;
   cmd_type       q_in, q_out;
   unit_req_type  unit_req;
   unit_rsp_type  unit_rsp;

   sca_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_data     (q_in),
      .q_full     (q_full)
   );

   sca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   sca_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .unit_req (unit_req),
      .unit_rsp (unit_rsp)
   );

   sca_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_out),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .unit_req   (unit_req),
      .unit_rsp   (unit_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ dv/stack_calculator_alu_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stack calculator ALU: directed table, then random commands.
module stack_calculator_alu_unit_test;
   import sca_pkg::*;

   localparam int         DEPTH        = STACK_DEPTH_DEF;
   localparam int         RANDOM_CMDS  = 2000;
   localparam int         CYCLE_LIMIT  = 2000000;
   localparam int         DRAIN_CYCLES = 60;
   localparam int         HOLD_CYCLES  = 500;
   localparam int         HOLD_AFTER   = 200;
   localparam logic [2:0] OP_UNUSED    = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [31:0] shown_value;
      logic        shown_valid;
   } calc_result_type;

   typedef struct packed {
      logic [2:0]      op;
      logic [31:0]     operand;
      logic            typed;
      calc_result_type res;
   } step_row_type;

   localparam calc_result_type NO_RES = '{ST_OK, 32'h0, 1'b0};
   localparam logic [2:0] ARITH_OPS [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'h0;    // [31:0] operand
   logic [2:0]  req_tuser = 3'h0;     // [2:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] shown_value
   logic [3:0]  rsp_tuser;            // [2:0] status, [3] shown_valid

   logic [31:0]     calc_stack [DEPTH];
   int              calc_depth = 0;
   calc_result_type pending_results [$];

   int mismatch_count = 0;
   int rsp_seen       = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int over_left      = 2;
   bit fill_mode      = 1'b1;
   bit drain_mode     = 1'b0;
   bit rx_holding     = 1'b0;
   bit pressure_done  = 1'b0;

   step_row_type directed_steps [0:23] = '{
      '{OP_OUT,    32'h1234_5678, 1'b1, '{ST_UNDER, 32'h0, 1'b0}},
      '{OP_ADD,    32'h0,         1'b1, '{ST_UNDER, 32'h0, 1'b0}},
      '{OP_SQRT,   32'h0,         1'b1, '{ST_UNDER, 32'h0, 1'b0}},
      '{OP_PUSH,   32'h7fff_ffff, 1'b1, NO_RES},
      '{OP_DIV,    32'h0,         1'b1, '{ST_UNDER, 32'h0, 1'b0}},
      '{OP_PUSH,   32'h8000_0000, 1'b1, NO_RES},
      '{OP_ADD,    32'hffff_ffff, 1'b0, NO_RES},
      '{OP_PUSH,   32'h0,         1'b1, NO_RES},
      '{OP_DIV,    32'h0,         1'b1, '{ST_DIVZERO, 32'h0, 1'b0}},
      '{OP_OUT,    32'hffff_ffff, 1'b1, '{ST_OK, 32'h0, 1'b1}},
      '{OP_SQRT,   32'h0,         1'b1, '{ST_NEGSQRT, 32'h0, 1'b0}},
      '{OP_OUT,    32'h0,         1'b1, '{ST_OK, 32'hffff_ffff, 1'b1}},
      '{OP_PUSH,   32'h8000_0000, 1'b1, NO_RES},
      '{OP_PUSH,   32'hffff_ffff, 1'b1, NO_RES},
      '{OP_DIV,    32'h5555_5555, 1'b0, NO_RES},
      '{OP_OUT,    32'h0,         1'b1, '{ST_OK, 32'h8000_0000, 1'b1}},
      '{OP_PUSH,   32'h7fff_ffff, 1'b1, NO_RES},
      '{OP_SQRT,   32'h0,         1'b0, NO_RES},
      '{OP_PUSH,   32'h7fff_ffff, 1'b1, NO_RES},
      '{OP_MUL,    32'h0,         1'b0, NO_RES},
      '{OP_PUSH,   32'h8000_0000, 1'b1, NO_RES},
      '{OP_SUB,    32'h0,         1'b0, NO_RES},
      '{OP_UNUSED, 32'h5a5a_5a5a, 1'b1, NO_RES},
      '{OP_OUT,    32'h0,         1'b0, NO_RES}
   };

   stack_calculator_alu_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic logic [31:0] isqrt(logic [31:0] v);
      logic [31:0] root;
      logic [31:0] cand;
      root = 32'h0;
      for (int b = 15; b >= 0; b--) begin
         cand = root | (32'd1 << b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   function automatic logic [31:0] trunc_div(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] q;
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      q = mag_n / mag_d;
      if (num[31] ^ den[31]) q = -q;
      return q;
   endfunction

   // Updates the local copy of the stack and returns the result of one command.
   function automatic calc_result_type predict_cmd(logic [2:0] op, logic [31:0] operand);
      calc_result_type r;
      logic [31:0]     lhs;
      logic [31:0]     rhs;
      r = NO_RES;
      case (op)
         OP_PUSH: begin
            if (calc_depth >= DEPTH) r.status = ST_OVER;
            else begin
               calc_stack[calc_depth] = operand;
               calc_depth++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (calc_depth < 2) r.status = ST_UNDER;
            else begin
               rhs = calc_stack[calc_depth-1];
               lhs = calc_stack[calc_depth-2];
               if (op == OP_DIV && rhs == 32'h0) r.status = ST_DIVZERO;
               else begin
                  case (op)
                     OP_ADD:  lhs = lhs + rhs;
                     OP_SUB:  lhs = lhs - rhs;
                     OP_MUL:  lhs = lhs * rhs;
                     default: lhs = trunc_div(lhs, rhs);
                  endcase
                  calc_stack[calc_depth-2] = lhs;
                  calc_depth--;
               end
            end
         end
         OP_SQRT: begin
            if (calc_depth < 1) r.status = ST_UNDER;
            else if (calc_stack[calc_depth-1][31]) r.status = ST_NEGSQRT;
            else calc_stack[calc_depth-1] = isqrt(calc_stack[calc_depth-1]);
         end
         OP_OUT: begin
            if (calc_depth < 1) r.status = ST_UNDER;
            else begin
               calc_depth--;
               r.shown_value = calc_stack[calc_depth];
               r.shown_valid = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0: w = 32'h0;
         1: w = 32'h1;
         2: w = 32'hffff_ffff;
         3: w = 32'h7fff_ffff;
         4: w = 32'h8000_0000;
         5, 6: begin
            w = $urandom_range(0, 300);
            if ($urandom_range(0, 1)) w = -w;
         end
         default: w = $urandom();
      endcase
      return w;
   endfunction

   // Mostly valid command streams; fill runs drive the stack to full and over, drains empty it.
   function automatic logic [2:0] pick_op();
      int r;
      int push_pct;
      if (fill_mode) begin
         if (calc_depth < DEPTH) return OP_PUSH;
         if (over_left > 0) begin
            over_left--;
            return OP_PUSH;
         end
         fill_mode  = 1'b0;
         drain_mode = 1'b1;
      end
      if (drain_mode) begin
         if (calc_depth == 0) drain_mode = 1'b0;
         r = $urandom_range(0, 9);
         if (r < 4) return OP_OUT;
         if (r < 5) return OP_SQRT;
         return ARITH_OPS[$urandom_range(0, 3)];
      end
      if ($urandom_range(0, 249) == 0) begin
         fill_mode = 1'b1;
         over_left = $urandom_range(1, 3);
      end
      r = $urandom_range(0, 99);
      push_pct = (calc_depth < 2) ? 70 : 45;
      if (r < push_pct) return OP_PUSH;
      if (r == 99) return OP_UNUSED;
      case (r % 7)
         0:       return OP_ADD;
         1:       return OP_SUB;
         2:       return OP_MUL;
         3, 4:    return OP_DIV;
         5:       return OP_SQRT;
         default: return OP_OUT;
      endcase
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic send_cmd(logic [2:0] op, logic [31:0] operand, calc_result_type exp);
      pending_results.push_back(exp);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= operand;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_pause();
      int gap;
      if (rx_holding || burst_left > 0) begin
         gap = 0;
         if (burst_left > 0) burst_left--;
      end else begin
         gap = idle_len();
         if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 100);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin : req_side
      calc_result_type exp;
      logic [2:0]      op;
      logic [31:0]     word;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_steps[i]) begin
         exp = predict_cmd(directed_steps[i].op, directed_steps[i].operand);
         if (directed_steps[i].typed) exp = directed_steps[i].res;
         send_cmd(directed_steps[i].op, directed_steps[i].operand, exp);
         sender_pause();
      end
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         op   = pick_op();
         word = pick_word();
         exp  = predict_cmd(op, word);
         send_cmd(op, word, exp);
         sender_pause();
      end
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin : rsp_side
      int ready_len;
      int stall_len;
      while (reset) @(negedge clock);
      forever begin
         if (!pressure_done && rsp_seen >= HOLD_AFTER) begin
            rx_holding    = 1'b1;
            pressure_done = 1'b1;
            ready_len     = 0;
            stall_len     = HOLD_CYCLES;
         end else begin
            ready_len = $urandom_range(1, 20);
            stall_len = idle_len();
         end
         repeat (ready_len) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
         repeat (stall_len) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end
         rx_holding = 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      calc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected transfer, status %0d shown %h valid %b",
                     $time, rsp_tuser[2:0], rsp_tdata, rsp_tuser[3]);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[2:0] != want.status) begin
               $display("%0t: status mismatch, expected %0d actual %0d",
                        $time, want.status, rsp_tuser[2:0]);
               mismatch_count++;
            end
            if (rsp_tdata != want.shown_value) begin
               $display("%0t: shown_value mismatch, expected %h actual %h",
                        $time, want.shown_value, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[3] != want.shown_valid) begin
               $display("%0t: shown_valid mismatch, expected %b actual %b",
                        $time, want.shown_valid, rsp_tuser[3]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
